// ----- rtl/scr_pkg.sv -----
// Shared types, constants and the segment pattern lookup for the seven-segment clock reader.
`timescale 1ns / 1ps
`default_nettype none
package scr_pkg;

    localparam int unsigned SUM_W       = 13;
    localparam int unsigned SEG_COUNT   = 7;
    localparam int unsigned PAT_COUNT   = 11;
    localparam int unsigned CLOCK_W     = 16;

    localparam logic [SUM_W-1:0] THRESHOLD_RESET = 13'd700;

    localparam logic [3:0] BLANK_CODE    = 4'd10;
    localparam logic [3:0] NO_MATCH      = 4'd15;
    localparam logic [1:0] LAST_POSITION = 2'd3;

    // Lit patterns for digits 0..9 and the all-blank pattern.
    localparam logic [6:0] DIGIT_PATTERNS [PAT_COUNT] = '{
        7'h7E, 7'h18, 7'h37, 7'h3D, 7'h59, 7'h6D, 7'h6F, 7'h38, 7'h7F, 7'h7D,
        7'h00
    };

    typedef struct packed {
        logic [SUM_W-1:0] seg_sum_upper_left;
        logic [SUM_W-1:0] seg_sum_top;
        logic [SUM_W-1:0] seg_sum_upper_right;
        logic [SUM_W-1:0] seg_sum_lower_right;
        logic [SUM_W-1:0] seg_sum_bottom;
        logic [SUM_W-1:0] seg_sum_lower_left;
        logic [SUM_W-1:0] seg_sum_middle;
    } t_seg_sums;

    typedef struct packed {
        logic [CLOCK_W-1:0] clock_value;
        logic               decode_error;
        logic [1:0]         error_digit;
        logic               tenths_format;
        logic               implausible_minutes;
    } t_clock_result;

    // Decoded digit: value already forced to zero for blank or failure.
    typedef struct packed {
        logic       fail;
        logic       blank;
        logic [3:0] value;
    } t_digit_info;

    // Frame summary handed to the time calculation.
    typedef struct packed {
        logic       error;
        logic [1:0] error_pos;
        logic       tenths;
        logic [3:0] d0;
        logic [3:0] d1;
        logic [3:0] d2;
        logic [3:0] d3;
    } t_frame_info;

    function automatic logic [3:0] match_pattern(input logic [6:0] lit);
        logic [3:0] code;
        code = NO_MATCH;
        for (int k = PAT_COUNT - 1; k >= 0; k--) begin
            if (DIGIT_PATTERNS[k] == lit) begin
                code = 4'(k);
            end
        end
        return code;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/scr_digit_decode.sv -----
// Threshold compare of seven segment sums and match against the digit patterns.
`timescale 1ns / 1ps
`default_nettype none
module scr_digit_decode (
    input  wire scr_pkg::t_seg_sums         i_sums,
    input  wire logic [scr_pkg::SUM_W-1:0]  i_threshold,
    output scr_pkg::t_digit_info            o_digit
);

    logic [6:0] lit;
    logic [3:0] code;

    always_comb begin
        lit[0] = i_sums.seg_sum_middle      > i_threshold;
        lit[1] = i_sums.seg_sum_lower_left  > i_threshold;
        lit[2] = i_sums.seg_sum_bottom      > i_threshold;
        lit[3] = i_sums.seg_sum_lower_right > i_threshold;
        lit[4] = i_sums.seg_sum_upper_right > i_threshold;
        lit[5] = i_sums.seg_sum_top         > i_threshold;
        lit[6] = i_sums.seg_sum_upper_left  > i_threshold;
    end

    assign code = scr_pkg::match_pattern(lit);

    always_comb begin
        o_digit.fail  = (code == scr_pkg::NO_MATCH);
        o_digit.blank = (code == scr_pkg::BLANK_CODE);
        // Drop the code to zero for blank and failed digits.
        o_digit.value = (o_digit.fail || o_digit.blank) ? 4'd0 : code;
    end

endmodule
`default_nettype wire

// ----- rtl/scr_time_calc.sv -----
// Time value in tenths of seconds and result flags from the four digits of a frame.
`timescale 1ns / 1ps
`default_nettype none
module scr_time_calc (
    input  wire scr_pkg::t_frame_info i_frame,
    output scr_pkg::t_clock_result    o_result
);

    localparam int unsigned W = scr_pkg::CLOCK_W;

    logic [W-1:0] d0;
    logic [W-1:0] d1;
    logic [W-1:0] d2;
    logic [W-1:0] d3;
    logic [W-1:0] normal_value;
    logic [W-1:0] tenths_value;

    assign d0 = W'(i_frame.d0);
    assign d1 = W'(i_frame.d1);
    assign d2 = W'(i_frame.d2);
    assign d3 = W'(i_frame.d3);

    // Constant multipliers reduce to shift-and-add trees.
    assign normal_value = d3 * 16'd6000 + d2 * 16'd600 + d1 * 16'd100 + d0 * 16'd10;
    assign tenths_value = d3 * 16'd100 + d2 * 16'd10 + d1;

    always_comb begin
        o_result.decode_error        = i_frame.error;
        o_result.error_digit         = i_frame.error ? i_frame.error_pos : 2'd0;
        o_result.clock_value         = '0;
        o_result.tenths_format       = 1'b0;
        o_result.implausible_minutes = 1'b0;
        if (!i_frame.error) begin
            if (i_frame.tenths) begin
                o_result.tenths_format = 1'b1;
                o_result.clock_value   = tenths_value;
            end else begin
                o_result.clock_value         = normal_value;
                o_result.implausible_minutes = (i_frame.d3 >= 4'd6);
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/seven_segment_clock_reader.sv -----
// Seven-segment clock reader: four digit beats in, one time result beat out.
// A digit beat is registered in the input stage and decoded from there; the result of the
// fourth digit is then loaded into the output register once that register is free.
// Throughput: one digit beat per cycle, sustained while the output side takes results.
// Reset (synchronous, active low) clears the frame state, both valid flags and sets the
// brightness threshold to 700.
`timescale 1ns / 1ps
`default_nettype none
module seven_segment_clock_reader (
    input  wire  logic                         i_clk,
    input  wire  logic                         i_rst_n,
    // configuration: brightness threshold
    input  wire  logic                         i_cfg_we,
    input  wire  logic [scr_pkg::SUM_W-1:0]    i_cfg_data,
    // digit input channel
    input  wire  logic                         i_in_valid,
    output logic                               o_in_stall,
    input  wire  scr_pkg::t_seg_sums           i_in_data,
    // result output channel
    output logic                               o_out_valid,
    input  wire  logic                         i_out_stall,
    output scr_pkg::t_clock_result             o_out_data
);

    // Threshold register.
    logic [scr_pkg::SUM_W-1:0] r_threshold;

    // Input register stage.
    logic                 r_a_valid;
    scr_pkg::t_seg_sums   r_a_data;

    // Frame state.
    logic [1:0]  r_pos;
    logic [3:0]  r_digits [3];
    logic        r_tenths;
    logic        r_err_seen;
    logic [1:0]  r_err_pos;

    // Output register.
    logic                   r_o_valid;
    scr_pkg::t_clock_result r_o_data;

    scr_pkg::t_digit_info   digit;
    scr_pkg::t_frame_info   frame;
    scr_pkg::t_clock_result result;

    logic a_last;
    logic out_free;
    logic a_go;
    logic in_accept;

    logic        n_tenths;
    logic        n_err_seen;
    logic [1:0]  n_err_pos;

    scr_digit_decode u_decode (
        .i_sums      (r_a_data),
        .i_threshold (r_threshold),
        .o_digit     (digit)
    );

    // The fourth digit closes the frame and needs a free output slot; earlier digits
    // only update the frame state and never wait.
    assign a_last    = (r_pos == scr_pkg::LAST_POSITION);
    assign out_free  = !r_o_valid || !i_out_stall;
    assign a_go      = r_a_valid && (!a_last || out_free);
    assign in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall = r_a_valid && !a_go;

    // Fold the current digit into the error and format flags.
    always_comb begin
        n_err_seen = r_err_seen;
        n_err_pos  = r_err_pos;
        n_tenths   = r_tenths;
        if (digit.fail && !r_err_seen) begin
            n_err_seen = 1'b1;
            n_err_pos  = r_pos;
        end
        // Blank leading digit selects seconds-and-tenths format.
        if (digit.blank && (r_pos == 2'd0)) begin
            n_tenths = 1'b1;
        end
    end

    always_comb begin
        frame.error     = n_err_seen;
        frame.error_pos = n_err_pos;
        frame.tenths    = n_tenths;
        frame.d0        = r_digits[0];
        frame.d1        = r_digits[1];
        frame.d2        = r_digits[2];
        frame.d3        = digit.value;
    end

    scr_time_calc u_calc (
        .i_frame  (frame),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= scr_pkg::THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_data;
        end
    end

    // Input stage: load on accept, drop once the beat has been processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_accept) begin
            r_a_valid <= 1'b1;
        end else if (a_go) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_a_data <= i_in_data;
        end
    end

    // Frame state: advance per digit, clear after the fourth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= 2'd0;
            r_tenths   <= 1'b0;
            r_err_seen <= 1'b0;
            r_err_pos  <= 2'd0;
            for (int i = 0; i < 3; i++) begin
                r_digits[i] <= 4'd0;
            end
        end else if (a_go) begin
            if (a_last) begin
                r_pos      <= 2'd0;
                r_tenths   <= 1'b0;
                r_err_seen <= 1'b0;
                r_err_pos  <= 2'd0;
                for (int i = 0; i < 3; i++) begin
                    r_digits[i] <= 4'd0;
                end
            end else begin
                r_pos      <= r_pos + 2'd1;
                r_tenths   <= n_tenths;
                r_err_seen <= n_err_seen;
                r_err_pos  <= n_err_pos;
                for (int i = 0; i < 3; i++) begin
                    if (r_pos == 2'(i)) begin
                        r_digits[i] <= digit.value;
                    end
                end
            end
        end
    end

    // Output register: hold the result until the far side takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (a_go && a_last) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_go && a_last) begin
            r_o_data <= result;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

endmodule
`default_nettype wire

// ----- test/tb_seven_segment_clock_reader.sv -----
// Self-checking testbench for the seven-segment clock reader: directed frames, then random ones.
`timescale 1ns / 1ps
module tb_seven_segment_clock_reader;

    localparam int FLAT_W = scr_pkg::SEG_COUNT * scr_pkg::SUM_W;
    localparam logic [scr_pkg::SUM_W-1:0] SUM_MAX       = '1;
    localparam logic [scr_pkg::SUM_W-1:0] THRESHOLD_TOP = 13'd6375;
    localparam int               PHASE_COUNT   = 8;
    localparam int               PHASE_BEATS   = 106;
    localparam int               DIRECTED_ROWS = 24;
    // result passes the input register and the output register; leave margin
    localparam int               SETTLE_CYCLES = 8;
    localparam int               IDLE_LIMIT    = 500;

    // How the seven sums of one digit beat are chosen.
    typedef enum logic [1:0] {
        ROW_GLYPH,      // random sums on the proper side of the threshold
        ROW_EDGE,       // lit at threshold + 1, dark exactly at threshold
        ROW_FULL_SCALE, // lit at full scale, dark at zero
        ROW_NOISE       // all 91 bits random
    } t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [3:0]             glyph;
        logic                   fixed_on;
        scr_pkg::t_clock_result fixed;
    } t_step_row;

    localparam scr_pkg::t_clock_result NO_FIXED = '0;

    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      cfg_we      = 1'b0;
    logic [scr_pkg::SUM_W-1:0] cfg_data    = '0;
    logic                      in_valid    = 1'b0;
    logic                      in_stall;
    scr_pkg::t_seg_sums        in_data     = '0;
    logic                      out_valid;
    logic                      out_stall   = 1'b0;
    scr_pkg::t_clock_result    out_data;

    // A typed-in expectation rides along with the digit beat that closes its frame.
    logic                      in_fixed_on = 1'b0;
    scr_pkg::t_clock_result    in_fixed    = '0;

    // Predictor state: threshold in force and the frame collected so far.
    logic [scr_pkg::SUM_W-1:0] seen_threshold = scr_pkg::THRESHOLD_RESET;
    logic [1:0]       frame_pos      = '0;
    logic [3:0]       frame_digits [3] = '{4'd0, 4'd0, 4'd0};
    logic             frame_tenths   = 1'b0;
    logic             frame_failed   = 1'b0;
    logic [1:0]       frame_fail_pos = '0;

    scr_pkg::t_clock_result clock_results_due [$];
    int unsigned      fail_count  = 0;
    int unsigned      idle_cycles = 0;
    int unsigned      stall_left  = 0;
    // set for the closing phase: no gaps, no stalls
    logic             steady_flow = 1'b0;

    seven_segment_clock_reader uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Lit pattern per glyph; bit j is segment j, middle first, upper left last.
    function automatic logic [6:0] glyph_bits(input logic [3:0] glyph);
        case (glyph)
            4'd0:    return 7'h7E;
            4'd1:    return 7'h18;
            4'd2:    return 7'h37;
            4'd3:    return 7'h3D;
            4'd4:    return 7'h59;
            4'd5:    return 7'h6D;
            4'd6:    return 7'h6F;
            4'd7:    return 7'h38;
            4'd8:    return 7'h7F;
            4'd9:    return 7'h7D;
            default: return 7'h00; // blank
        endcase
    endfunction

    // Glyph shown by a lit pattern, or NO_MATCH when it is none of the eleven.
    function automatic logic [3:0] glyph_of(input logic [6:0] lit);
        logic [3:0] glyph;
        glyph = scr_pkg::NO_MATCH;
        for (int k = 0; k <= int'(scr_pkg::BLANK_CODE); k++) begin
            if (glyph == scr_pkg::NO_MATCH && glyph_bits(4'(k)) == lit) begin
                glyph = 4'(k);
            end
        end
        return glyph;
    endfunction

    // Build one digit beat. The packed beat carries the middle sum in its low bits,
    // so segment j lives at bits [j*SUM_W +: SUM_W].
    function automatic scr_pkg::t_seg_sums build_sums(input t_row_kind kind,
                                                      input logic [3:0] glyph);
        logic [6:0]                lit;
        logic [FLAT_W-1:0]         flat;
        logic [scr_pkg::SUM_W-1:0] sum;
        flat = FLAT_W'({$urandom, $urandom, $urandom});
        lit  = glyph_bits(glyph);
        if (glyph == scr_pkg::NO_MATCH) begin
            // pick a stray pattern that no glyph uses
            do lit = 7'($urandom); while (glyph_of(lit) != scr_pkg::NO_MATCH);
        end
        if (kind != ROW_NOISE) begin
            for (int j = 0; j < scr_pkg::SEG_COUNT; j++) begin
                case (kind)
                    ROW_FULL_SCALE: sum = lit[j] ? SUM_MAX : '0;
                    ROW_EDGE:       sum = lit[j] ? seen_threshold + 1'b1 : seen_threshold;
                    default: begin
                        if (lit[j]) begin
                            sum = scr_pkg::SUM_W'($urandom_range(int'(SUM_MAX),
                                                                 int'(seen_threshold) + 1));
                        end else begin
                            sum = scr_pkg::SUM_W'($urandom_range(int'(seen_threshold), 0));
                        end
                    end
                endcase
                flat[j*scr_pkg::SUM_W +: scr_pkg::SUM_W] = sum;
            end
        end
        return scr_pkg::t_seg_sums'(flat);
    endfunction

    // Advance the frame by one digit beat; on the fourth digit return the time it shows.
    function automatic void read_clock_digit(input scr_pkg::t_seg_sums sums, output logic done,
                                             output scr_pkg::t_clock_result result);
        logic [FLAT_W-1:0] flat;
        logic [6:0]        lit;
        logic [3:0]        glyph;
        logic [3:0]        value;
        int unsigned       total;
        flat   = sums;
        value  = '0;
        total  = 0;
        result = '0;
        done   = 1'b0;
        for (int j = 0; j < scr_pkg::SEG_COUNT; j++) begin
            lit[j] = flat[j*scr_pkg::SUM_W +: scr_pkg::SUM_W] > seen_threshold;
        end
        glyph = glyph_of(lit);
        if (glyph == scr_pkg::NO_MATCH) begin
            // keep only the first failing position
            if (!frame_failed) begin
                frame_failed   = 1'b1;
                frame_fail_pos = frame_pos;
            end
        end else if (glyph == scr_pkg::BLANK_CODE) begin
            // blank leading digit switches to seconds-and-tenths; elsewhere it reads as zero
            if (frame_pos == 2'd0) begin
                frame_tenths = 1'b1;
            end
        end else begin
            value = glyph;
        end

        if (frame_pos != scr_pkg::LAST_POSITION) begin
            frame_digits[frame_pos] = value;
            frame_pos = frame_pos + 2'd1;
            return;
        end

        done                = 1'b1;
        result.decode_error = frame_failed;
        result.error_digit  = frame_failed ? frame_fail_pos : 2'd0;
        if (!frame_failed) begin
            if (frame_tenths) begin
                result.tenths_format = 1'b1;
                total = frame_digits[1] + frame_digits[2] * 10 + value * 100;
            end else begin
                result.implausible_minutes = (value >= 4'd6);
                total = value * 6000 + frame_digits[2] * 600 + frame_digits[1] * 100
                      + frame_digits[0] * 10;
            end
            result.clock_value = scr_pkg::CLOCK_W'(total);
        end

        frame_pos      = '0;
        frame_digits   = '{4'd0, 4'd0, 4'd0};
        frame_tenths   = 1'b0;
        frame_failed   = 1'b0;
        frame_fail_pos = '0;
    endfunction

    // Offer one digit beat and hold it until the block takes it.
    task automatic push_digit(input scr_pkg::t_seg_sums sums, input logic fixed_on,
                              input scr_pkg::t_clock_result fixed);
        if (!steady_flow && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        in_data     <= sums;
        in_fixed_on <= fixed_on;
        in_fixed    <= fixed;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Drop valid, wait for every due result, then let digits that yield no result
    // clear the decode stage.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (clock_results_due.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [scr_pkg::SUM_W-1:0] value);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        seen_threshold = value;
    endtask

    // Result side: random stall bursts, none in the closing phase.
    always @(posedge clk) begin
        if (!rst_n || steady_flow) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(3, 0);
        end else begin
            out_stall  <= 1'b0;
        end
    end

    // Predict on every accepted digit beat, check every accepted result beat,
    // and stop the run if the handshakes go quiet for too long.
    always @(posedge clk) begin : scoreboard
        logic                   frame_done;
        logic                   moved;
        scr_pkg::t_clock_result predicted;
        scr_pkg::t_clock_result due;
        if (rst_n) begin
            moved = 1'b0;
            if (in_valid && !in_stall) begin
                moved = 1'b1;
                read_clock_digit(in_data, frame_done, predicted);
                if (frame_done) begin
                    clock_results_due.push_back(in_fixed_on ? in_fixed : predicted);
                end
            end
            if (out_valid && !out_stall) begin
                moved = 1'b1;
                if (clock_results_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: result beat with nothing due, got clock_value %0d error %0b",
                             $time, out_data.clock_value, out_data.decode_error);
                end else begin
                    due = clock_results_due.pop_front();
                    if (due.clock_value !== out_data.clock_value) begin
                        fail_count++;
                        $display("%0t: clock_value expected %0d, got %0d",
                                 $time, due.clock_value, out_data.clock_value);
                    end
                    if (due.decode_error !== out_data.decode_error) begin
                        fail_count++;
                        $display("%0t: decode_error expected %0b, got %0b",
                                 $time, due.decode_error, out_data.decode_error);
                    end
                    if (due.error_digit !== out_data.error_digit) begin
                        fail_count++;
                        $display("%0t: error_digit expected %0d, got %0d",
                                 $time, due.error_digit, out_data.error_digit);
                    end
                    if (due.tenths_format !== out_data.tenths_format) begin
                        fail_count++;
                        $display("%0t: tenths_format expected %0b, got %0b",
                                 $time, due.tenths_format, out_data.tenths_format);
                    end
                    if (due.implausible_minutes !== out_data.implausible_minutes) begin
                        fail_count++;
                        $display("%0t: implausible_minutes expected %0b, got %0b",
                                 $time, due.implausible_minutes, out_data.implausible_minutes);
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_step_row                 steps [DIRECTED_ROWS];
        logic [scr_pkg::SUM_W-1:0] plan [PHASE_COUNT];
        t_row_kind                 kind;
        logic [3:0]                glyph;
        int                        roll;
        int unsigned               sent;

        // Directed frames at the reset threshold, four digits each, seconds digit first.
        // Full-scale nines, with one nine right at the threshold edge: the largest time.
        steps[0]  = '{ROW_FULL_SCALE, 4'd9, 1'b0, NO_FIXED};
        steps[1]  = '{ROW_FULL_SCALE, 4'd9, 1'b0, NO_FIXED};
        steps[2]  = '{ROW_EDGE,       4'd9, 1'b0, NO_FIXED};
        steps[3]  = '{ROW_FULL_SCALE, 4'd9, 1'b1, '{16'd60390, 1'b0, 2'd0, 1'b0, 1'b1}};
        // All-dark leading digit selects seconds-and-tenths: 99.9 s
        steps[4]  = '{ROW_FULL_SCALE, scr_pkg::BLANK_CODE, 1'b0, NO_FIXED};
        steps[5]  = '{ROW_EDGE,       4'd9, 1'b0, NO_FIXED};
        steps[6]  = '{ROW_GLYPH,      4'd9, 1'b0, NO_FIXED};
        steps[7]  = '{ROW_GLYPH,      4'd9, 1'b1, '{16'd999, 1'b0, 2'd0, 1'b1, 1'b0}};
        // Unreadable third digit
        steps[8]  = '{ROW_GLYPH,      4'd1, 1'b0, NO_FIXED};
        steps[9]  = '{ROW_GLYPH,      4'd2, 1'b0, NO_FIXED};
        steps[10] = '{ROW_GLYPH,      scr_pkg::NO_MATCH, 1'b0, NO_FIXED};
        steps[11] = '{ROW_GLYPH,      4'd3, 1'b1, '{16'd0, 1'b1, 2'd2, 1'b0, 1'b0}};
        // Tenths format masked by an unreadable second digit
        steps[12] = '{ROW_GLYPH,      scr_pkg::BLANK_CODE, 1'b0, NO_FIXED};
        steps[13] = '{ROW_GLYPH,      scr_pkg::NO_MATCH, 1'b0, NO_FIXED};
        steps[14] = '{ROW_GLYPH,      4'd4, 1'b0, NO_FIXED};
        steps[15] = '{ROW_GLYPH,      4'd4, 1'b1, '{16'd0, 1'b1, 2'd1, 1'b0, 1'b0}};
        // Unreadable last digit
        steps[16] = '{ROW_GLYPH,      4'd7, 1'b0, NO_FIXED};
        steps[17] = '{ROW_GLYPH,      4'd6, 1'b0, NO_FIXED};
        steps[18] = '{ROW_GLYPH,      4'd5, 1'b0, NO_FIXED};
        steps[19] = '{ROW_GLYPH,      scr_pkg::NO_MATCH, 1'b1,
                      '{16'd0, 1'b1, 2'd3, 1'b0, 1'b0}};
        // All sums at full scale, a zero, a blank inside the frame, tens of minutes six
        steps[20] = '{ROW_FULL_SCALE, 4'd8, 1'b0, NO_FIXED};
        steps[21] = '{ROW_GLYPH,      4'd0, 1'b0, NO_FIXED};
        steps[22] = '{ROW_EDGE,       scr_pkg::BLANK_CODE, 1'b0, NO_FIXED};
        steps[23] = '{ROW_GLYPH,      4'd6, 1'b0, NO_FIXED};

        // Threshold per random phase: both ends of the range, the 13-bit ceiling
        // (nothing can light), random picks, and back to the reset value.
        plan[0] = '0;
        plan[1] = THRESHOLD_TOP;
        plan[2] = SUM_MAX;
        plan[3] = scr_pkg::SUM_W'($urandom_range(int'(THRESHOLD_TOP), 0));
        plan[4] = scr_pkg::SUM_W'($urandom_range(1500, 200));
        plan[5] = scr_pkg::SUM_W'($urandom_range(int'(SUM_MAX), 0));
        plan[6] = 13'd1;
        plan[7] = scr_pkg::THRESHOLD_RESET;
        sent    = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (steps[i]) begin
            push_digit(build_sums(steps[i].kind, steps[i].glyph), steps[i].fixed_on,
                       steps[i].fixed);
            sent++;
        end

        // Random phases end mid-frame, so frames straddle threshold changes.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_threshold(plan[p]);
            if (p == PHASE_COUNT - 1) begin
                steady_flow <= 1'b1;
            end
            for (int n = 0; n < PHASE_BEATS; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 4) begin
                    kind = ROW_NOISE;
                end else if (roll < 10) begin
                    kind = ROW_EDGE;
                end else if (roll < 15) begin
                    kind = ROW_FULL_SCALE;
                end else begin
                    kind = ROW_GLYPH;
                end
                // favor a blank leading digit so tenths frames come up often
                roll = $urandom_range(0, 99);
                if (roll < 4) begin
                    glyph = scr_pkg::NO_MATCH;
                end else if (roll < ((sent % 4 == 0) ? 30 : 10)) begin
                    glyph = scr_pkg::BLANK_CODE;
                end else begin
                    glyph = 4'($urandom_range(9, 0));
                end
                push_digit(build_sums(kind, glyph), 1'b0, NO_FIXED);
                sent++;
            end
        end

        drain_results();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
